>>> rtl/wvft_pkg.sv
// shared types and status codes for the wormhole vc forwarding table unit
// no dependencies
package wvft_pkg;

  localparam int PORT_W    = 3;
  localparam int VC_W      = 2;
  localparam int PAYLOAD_W = 64;
  localparam int STATUS_W  = 3;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TX_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OWNED_OTHER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HEAD_HELD    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BODY_UNOWNED = 3'd4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_OWN_PORT = 1'b0;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic                 head;
    logic                 tail;
    logic [PORT_W-1:0]    port;
    logic [VC_W-1:0]      src_vc;
    logic [VC_W-1:0]      dest_vc;
    logic                 tx_ready;
  } flit_t;

  typedef struct packed {
    logic                forwarded;
    logic [STATUS_W-1:0] status;
  } tbl_res_t;

endpackage

>>> rtl/wvft_cfg.sv
// configuration register block, apb-style write and read
// depends on wvft_pkg
module wvft_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wvft_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wvft_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wvft_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [wvft_pkg::PORT_W-1:0]      own_port
);
  import wvft_pkg::*;

  logic [PORT_W-1:0] own_port_r;
  logic [PORT_W-1:0] own_port_nxt;
  logic              wr_en;
  logic              sel_own;

  assign pready  = 1'b1;
  assign sel_own = (paddr[2] == CFG_IDX_OWN_PORT);
  assign wr_en   = psel && penable && pwrite && pready && sel_own;

  always_comb begin
    own_port_nxt = own_port_r;
    if (wr_en) begin
      own_port_nxt = pwdata[PORT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_port_r <= '0;
    end else begin
      own_port_r <= own_port_nxt;
    end
  end

  assign prdata   = sel_own ? {{(CFG_DATA_W-PORT_W){1'b0}}, own_port_r} : '0;
  assign own_port = own_port_r;

endmodule

>>> rtl/wvft_own_table.sv
// ownership table with per-entry valid bits, check and claim/release update
// depends on wvft_pkg
module wvft_own_table #(
  parameter int NUM_PORTS = 8,
  parameter int NUM_VCS   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wvft_pkg::flit_t    flit,
  output wvft_pkg::tbl_res_t res
);
  import wvft_pkg::*;

  localparam int DEPTH = NUM_PORTS * NUM_VCS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0] PORT_LIM = 5'(NUM_PORTS);
  localparam logic [4:0] VC_LIM   = 5'(NUM_VCS);

  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic [VC_W-1:0]  vc_r [DEPTH];

  logic             rng_ok;
  logic [7:0]       idx_full;
  logic [IDX_W-1:0] idx;
  logic             held;
  logic [VC_W-1:0]  owner;
  logic [STATUS_W-1:0] status;
  logic             ok;
  logic             claim;
  logic             release_e;

  assign rng_ok   = flit.tx_ready && ({2'b00, flit.port} < PORT_LIM)
                    && ({3'b000, flit.dest_vc} < VC_LIM);
  assign idx_full = 8'(flit.port) * 8'(NUM_VCS) + 8'(flit.dest_vc);
  assign idx      = rng_ok ? idx_full[IDX_W-1:0] : '0;
  assign held     = valid_r[idx];
  assign owner    = vc_r[idx];

  always_comb begin
    priority if (!rng_ok) begin
      status = ST_TX_FULL;
    end else if (held && (owner != flit.src_vc)) begin
      status = ST_OWNED_OTHER;
    end else if (flit.head && held) begin
      status = ST_HEAD_HELD;
    end else if (!flit.head && !held) begin
      status = ST_BODY_UNOWNED;
    end else begin
      status = ST_OK;
    end
  end

  assign ok        = en && (status == ST_OK);
  assign claim     = ok && flit.head && !flit.tail;
  assign release_e = ok && !flit.head && flit.tail;

  always_comb begin
    valid_nxt = valid_r;
    if (claim) begin
      valid_nxt[idx] = 1'b1;
    end else if (release_e) begin
      valid_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      vc_r[idx] <= flit.src_vc;
    end
  end

  assign res.forwarded = (status == ST_OK);
  assign res.status    = status;

endmodule

>>> rtl/wormhole_vc_forwarding_table_unit.sv
// wormhole vc forwarding table unit: input register, ownership check, result register
// depends on wvft_pkg, wvft_cfg, wvft_own_table
// the result strobe out_valid follows a start transfer through item_v_r and out_valid_r
// throughput: one flit per cycle, busy stays low, the receiver cannot stall
// the ownership table is a row of flip-flops, read and updated in the check stage
// reset (synchronous, active low) frees every table entry at once and clears own_port
module wormhole_vc_forwarding_table_unit #(
  parameter int NUM_PORTS = 8,
  parameter int NUM_VCS   = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [wvft_pkg::PAYLOAD_W-1:0]    in_flit_payload,
  input  logic                              in_is_head,
  input  logic                              in_is_tail,
  input  logic [wvft_pkg::PORT_W-1:0]       in_dest_port,
  input  logic [wvft_pkg::VC_W-1:0]         in_src_vc,
  input  logic [wvft_pkg::VC_W-1:0]         in_dest_vc,
  input  logic                              in_tx_ready,
  output logic                              out_valid,
  output logic                              out_forwarded,
  output logic [wvft_pkg::STATUS_W-1:0]     out_status,
  output logic [wvft_pkg::PORT_W-1:0]       out_port,
  output logic [wvft_pkg::VC_W-1:0]         out_vc,
  output logic [wvft_pkg::PORT_W-1:0]       out_source_port,
  output logic [wvft_pkg::PAYLOAD_W-1:0]    out_payload,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wvft_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wvft_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wvft_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import wvft_pkg::*;

  logic              accept;
  logic              item_v_r;
  flit_t             item_r;
  flit_t             item_nxt;
  tbl_res_t          res;
  logic [PORT_W-1:0] own_port;

  logic                 out_valid_r;
  logic                 out_fwd_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [PORT_W-1:0]    out_port_r;
  logic [VC_W-1:0]      out_vc_r;
  logic [PORT_W-1:0]    out_src_r;
  logic [PAYLOAD_W-1:0] out_payload_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign item_nxt.payload  = in_flit_payload;
  assign item_nxt.head     = in_is_head;
  assign item_nxt.tail     = in_is_tail;
  assign item_nxt.port     = in_dest_port;
  assign item_nxt.src_vc   = in_src_vc;
  assign item_nxt.dest_vc  = in_dest_vc;
  assign item_nxt.tx_ready = in_tx_ready;

  wvft_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .own_port (own_port)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  wvft_own_table #(
    .NUM_PORTS (NUM_PORTS),
    .NUM_VCS   (NUM_VCS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (item_v_r),
    .flit  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_v_r) begin
      out_fwd_r     <= res.forwarded;
      out_status_r  <= res.status;
      out_port_r    <= res.forwarded ? item_r.port : '0;
      out_vc_r      <= res.forwarded ? item_r.dest_vc : '0;
      out_src_r     <= res.forwarded ? own_port : '0;
      out_payload_r <= res.forwarded ? item_r.payload : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_forwarded   = out_valid_r && out_fwd_r;
  assign out_status      = out_status_r;
  assign out_port        = out_port_r;
  assign out_vc          = out_vc_r;
  assign out_source_port = out_src_r;
  assign out_payload     = out_payload_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("no result two cycles after a start transfer");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_forwarded) |-> (out_status != ST_OK && out_payload == '0
      && out_port == '0 && out_source_port == '0))
    else $error("dropped flit carries data or ok status");

  a_fwd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_forwarded |-> (out_status == ST_OK))
    else $error("forwarded flit with error status");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(item_v_r))
    else $error("result without a flit in the check stage");

endmodule

>>> verif/wvft_checker.sv
// checker for the wormhole vc forwarding table unit: tracks vc ownership per output
// port and vc, predicts each result and compares it with the result port
// depends on wvft_pkg
`timescale 1ns / 100ps
module wvft_checker #(
  parameter int NUM_PORTS = 8,
  parameter int NUM_VCS   = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [wvft_pkg::PAYLOAD_W-1:0]    in_flit_payload,
  input  logic                              in_is_head,
  input  logic                              in_is_tail,
  input  logic [wvft_pkg::PORT_W-1:0]       in_dest_port,
  input  logic [wvft_pkg::VC_W-1:0]         in_src_vc,
  input  logic [wvft_pkg::VC_W-1:0]         in_dest_vc,
  input  logic                              in_tx_ready,
  input  logic                              out_valid,
  input  logic                              out_forwarded,
  input  logic [wvft_pkg::STATUS_W-1:0]     out_status,
  input  logic [wvft_pkg::PORT_W-1:0]       out_port,
  input  logic [wvft_pkg::VC_W-1:0]         out_vc,
  input  logic [wvft_pkg::PORT_W-1:0]       out_source_port,
  input  logic [wvft_pkg::PAYLOAD_W-1:0]    out_payload,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wvft_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wvft_pkg::CFG_DATA_W-1:0]   pwdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending
);
  import wvft_pkg::*;

  localparam int TABLE_SIZE = NUM_PORTS * NUM_VCS;
  localparam logic [CFG_ADDR_W-1:0] OWN_PORT_ADDR = {CFG_IDX_OWN_PORT, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 forwarded;
    logic [STATUS_W-1:0]  status;
    logic [PORT_W-1:0]    port;
    logic [VC_W-1:0]      vc;
    logic [PORT_W-1:0]    src_port;
    logic [PAYLOAD_W-1:0] payload;
  } verdict_t;

  logic                owned    [TABLE_SIZE];
  logic [VC_W-1:0]     owner_of [TABLE_SIZE];
  logic [PORT_W-1:0]   own_port;
  verdict_t            pending_verdicts [$];

  function automatic verdict_t judge_flit(input flit_t f);
    verdict_t v;
    int       idx;
    logic     held;
    v    = '0;
    idx  = 0;
    held = 1'b0;
    if (!f.tx_ready || f.port >= NUM_PORTS || f.dest_vc >= NUM_VCS) begin
      v.status = ST_TX_FULL;
    end else begin
      idx  = f.port * NUM_VCS + f.dest_vc;
      held = owned[idx];
      if (held && owner_of[idx] != f.src_vc) begin
        v.status = ST_OWNED_OTHER;
      end else if (f.head && held) begin
        v.status = ST_HEAD_HELD;
      end else if (!f.head && !held) begin
        v.status = ST_BODY_UNOWNED;
      end else begin
        v.status = ST_OK;
      end
    end
    if (v.status == ST_OK) begin
      // head claims, tail frees, single-flit packets leave the entry alone
      if (f.head && !f.tail) begin
        owned[idx]    = 1'b1;
        owner_of[idx] = f.src_vc;
      end else if (!f.head && f.tail) begin
        owned[idx]    = 1'b0;
        owner_of[idx] = '0;
      end
      v.forwarded = 1'b1;
      v.port      = f.port;
      v.vc        = f.dest_vc;
      v.src_port  = own_port;
      v.payload   = f.payload;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    flit_t    f;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        owned[i]    = 1'b0;
        owner_of[i] = '0;
      end
      own_port = '0;
      pending_verdicts.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_forwarded, out_status, out_port, out_vc, out_source_port, out_payload};
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result fwd=%0d status=%0d", $realtime,
                     got.forwarded, got.status);
        end else begin
          want = pending_verdicts.pop_front();
          if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch exp fwd=%0d st=%0d port=%0d vc=%0d src=%0d data=%h,",
                       $realtime, want.forwarded, want.status, want.port, want.vc,
                       want.src_port, want.payload,
                       " got fwd=%0d st=%0d port=%0d vc=%0d src=%0d data=%h",
                       got.forwarded, got.status, got.port, got.vc, got.src_port,
                       got.payload);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == OWN_PORT_ADDR)
        own_port = pwdata[PORT_W-1:0];
      if (start && !busy) begin
        f = '{in_flit_payload, in_is_head, in_is_tail, in_dest_port, in_src_vc,
              in_dest_vc, in_tx_ready};
        pending_verdicts.push_back(judge_flit(f));
      end
      pending <= pending_verdicts.size();
    end
  end

endmodule

>>> verif/wormhole_vc_forwarding_table_unit_tb.sv
// testbench top for the wormhole vc forwarding table unit: clock, reset, apb writes
// and flit stimulus (directed cases, then interleaved packets per input vc plus noise)
// depends on wvft_pkg, wvft_checker and the unit itself
`timescale 1ns / 100ps
module wormhole_vc_forwarding_table_unit_tb;
  import wvft_pkg::*;

  localparam int NUM_PORTS       = 8;
  localparam int NUM_VCS         = 4;
  localparam int DRAIN_CYCLES    = 4;
  localparam int FLITS_PER_PHASE = 235;
  localparam logic [CFG_ADDR_W-1:0] OWN_PORT_ADDR = {CFG_IDX_OWN_PORT, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [PAYLOAD_W-1:0]  in_flit_payload;
  logic                  in_is_head;
  logic                  in_is_tail;
  logic [PORT_W-1:0]     in_dest_port;
  logic [VC_W-1:0]       in_src_vc;
  logic [VC_W-1:0]       in_dest_vc;
  logic                  in_tx_ready;
  logic                  out_valid;
  logic                  out_forwarded;
  logic [STATUS_W-1:0]   out_status;
  logic [PORT_W-1:0]     out_port;
  logic [VC_W-1:0]       out_vc;
  logic [PORT_W-1:0]     out_source_port;
  logic [PAYLOAD_W-1:0]  out_payload;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    results_owed;
  int                    idle_pct;

  // one packet in flight per input vc
  logic                  lane_busy [NUM_VCS];
  logic [PORT_W-1:0]     lane_port [NUM_VCS];
  logic [VC_W-1:0]       lane_vc   [NUM_VCS];
  int                    lane_left [NUM_VCS];

  wormhole_vc_forwarding_table_unit #(
    .NUM_PORTS(NUM_PORTS),
    .NUM_VCS  (NUM_VCS)
  ) u_top (.*);

  wvft_checker #(
    .NUM_PORTS(NUM_PORTS),
    .NUM_VCS  (NUM_VCS)
  ) u_check (
    .*,
    .fail_count(fail_count),
    .pending   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic flit_t make_flit(input logic [PAYLOAD_W-1:0] payload, input logic head,
                                      input logic tail, input logic [PORT_W-1:0] port,
                                      input logic [VC_W-1:0] svc, input logic [VC_W-1:0] dvc,
                                      input logic rdy);
    flit_t f;
    f = '{payload, head, tail, port, svc, dvc, rdy};
    return f;
  endfunction

  task automatic send_flit(input flit_t f);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_flit_payload <= f.payload;
    in_is_head      <= f.head;
    in_is_tail      <= f.tail;
    in_dest_port    <= f.port;
    in_src_vc       <= f.src_vc;
    in_dest_vc      <= f.dest_vc;
    in_tx_ready     <= f.tx_ready;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PORT_W-1:0] port_id);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OWN_PORT_ADDR;
    pwdata  <= CFG_DATA_W'(port_id);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input int idle, input logic [PORT_W-1:0] port_id);
    flit_t f;
    int    s;
    logic  collide;
    logic  taken;
    drain();
    cfg_write(port_id);
    idle_pct = idle;
    repeat (FLITS_PER_PHASE) begin
      f = make_flit({$urandom, $urandom}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), PORT_W'($urandom_range(0, NUM_PORTS - 1)),
                    VC_W'($urandom_range(0, NUM_VCS - 1)),
                    VC_W'($urandom_range(0, NUM_VCS - 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) >= 10) begin
        s           = $urandom_range(0, NUM_VCS - 1);
        f.src_vc    = VC_W'(s);
        f.tx_ready  = 1'b1;
        if (!lane_busy[s]) begin
          // new packet: usually on an entry no other lane holds, sometimes a clash
          collide = ($urandom_range(0, 9) == 0);
          do begin
            lane_port[s] = PORT_W'($urandom_range(0, NUM_PORTS - 1));
            lane_vc[s]   = VC_W'($urandom_range(0, NUM_VCS - 1));
            taken        = 1'b0;
            for (int j = 0; j < NUM_VCS; j++)
              if (j != s && lane_busy[j] && lane_port[j] == lane_port[s] &&
                  lane_vc[j] == lane_vc[s])
                taken = 1'b1;
          end while (taken && !collide);
          lane_left[s] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          f.head       = 1'b1;
          f.tail       = (lane_left[s] == 0);
          lane_busy[s] = (lane_left[s] != 0);
        end else begin
          lane_left[s]--;
          f.head = 1'b0;
          f.tail = (lane_left[s] == 0);
          if (f.tail)
            lane_busy[s] = 1'b0;
        end
        f.port    = lane_port[s];
        f.dest_vc = lane_vc[s];
        if ($urandom_range(0, 99) < 8) begin
          f.tx_ready = 1'b0;
          send_flit(f);
          f.tx_ready = 1'b1;
        end
      end
      send_flit(f);
    end
  endtask

  initial begin
    logic [PAYLOAD_W-1:0] p;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_flit_payload <= '0;
    in_is_head      <= 1'b0;
    in_is_tail      <= 1'b0;
    in_dest_port    <= '0;
    in_src_vc       <= '0;
    in_dest_vc      <= '0;
    in_tx_ready     <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    idle_pct        = 28;
    for (int i = 0; i < NUM_VCS; i++) begin
      lane_busy[i] = 1'b0;
      lane_port[i] = '0;
      lane_vc[i]   = '0;
      lane_left[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(3'd5);

    p = {$urandom, $urandom};
    send_flit(make_flit('0, 1'b0, 1'b0, 3'd0, 2'd0, 2'd0, 1'b0));  // transmitter full
    send_flit(make_flit('1, 1'b0, 1'b0, 3'd2, 2'd1, 2'd3, 1'b1));  // body on free entry
    send_flit(make_flit(p, 1'b0, 1'b1, 3'd2, 2'd1, 2'd3, 1'b1));   // tail on free entry
    send_flit(make_flit(p, 1'b1, 1'b0, 3'd2, 2'd1, 2'd3, 1'b1));   // head claims
    send_flit(make_flit(~p, 1'b1, 1'b0, 3'd2, 2'd1, 2'd3, 1'b1));  // head on own held entry
    send_flit(make_flit(p, 1'b1, 1'b0, 3'd2, 2'd2, 2'd3, 1'b1));   // head, other owner
    send_flit(make_flit(p, 1'b0, 1'b0, 3'd2, 2'd0, 2'd3, 1'b1));   // body, other owner
    send_flit(make_flit('1, 1'b0, 1'b0, 3'd2, 2'd1, 2'd3, 1'b1));  // body forwarded
    send_flit(make_flit(p, 1'b1, 1'b1, 3'd2, 2'd1, 2'd3, 1'b1));   // single flit on held
    send_flit(make_flit(p, 1'b0, 1'b0, 3'd2, 2'd1, 2'd3, 1'b0));   // held, not ready
    send_flit(make_flit(~p, 1'b0, 1'b1, 3'd2, 2'd1, 2'd3, 1'b1));  // tail frees
    send_flit(make_flit(p, 1'b0, 1'b0, 3'd2, 2'd1, 2'd3, 1'b1));   // body after free
    send_flit(make_flit('1, 1'b1, 1'b1, 3'd7, 2'd3, 2'd3, 1'b1));  // single flit on free
    send_flit(make_flit(p, 1'b0, 1'b0, 3'd7, 2'd3, 2'd3, 1'b1));   // entry still free
    send_flit(make_flit(p, 1'b1, 1'b0, 3'd7, 2'd3, 2'd3, 1'b1));
    send_flit(make_flit('0, 1'b0, 1'b0, 3'd7, 2'd3, 2'd3, 1'b1));
    send_flit(make_flit(p, 1'b0, 1'b1, 3'd7, 2'd0, 2'd3, 1'b1));   // tail, other owner
    send_flit(make_flit(p, 1'b0, 1'b1, 3'd7, 2'd3, 2'd3, 1'b1));
    send_flit(make_flit(~p, 1'b1, 1'b0, 3'd0, 2'd0, 2'd0, 1'b1));
    send_flit(make_flit(p, 1'b0, 1'b1, 3'd0, 2'd0, 2'd0, 1'b1));

    run_phase(28, 3'd7);
    run_phase(65, 3'd0);
    run_phase(0, PORT_W'($urandom_range(1, 6)));
    drain();

    if (fail_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wvft_pkg.sv
rtl/wvft_cfg.sv
rtl/wvft_own_table.sv
rtl/wormhole_vc_forwarding_table_unit.sv
verif/wvft_checker.sv
verif/wormhole_vc_forwarding_table_unit_tb.sv
